// ===== rtl/ild_pkg.sv =====
// ----------------------------------------------------------------------------
// ild_pkg
// Shared types and constants for the IMU linear downsampler.
// ----------------------------------------------------------------------------
package ild_pkg;

  // Fixed field widths
  localparam int unsigned RATE_W  = 16;
  localparam int unsigned SCALE_W = 17;
  localparam int unsigned PHASE_W = 17;
  localparam int unsigned RATIO_W = 18;
  localparam int unsigned RES_W   = 32;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned ADDR_W  = 4;

  // Saturation limits of a result field
  localparam logic [RES_W-1:0] RES_MAX = 32'h7fff_ffff;
  localparam logic [RES_W-1:0] RES_MIN = 32'h8000_0000;

  // Phase accumulator ceiling
  localparam logic [PHASE_W-1:0] PHASE_MAX = 17'h1_ffff;

  // Register reset values
  localparam logic [RATE_W-1:0]  RATE_MULT_RST = 16'd1;
  localparam logic [RATE_W-1:0]  RATE_DIV_RST  = 16'd1;
  localparam logic [SCALE_W-1:0] INV_SCALE_RST = 17'h1_0000;

  // Register index codes (paddr[3:2])
  localparam logic [1:0] REG_RATE_MULT = 2'd0;
  localparam logic [1:0] REG_RATE_DIV  = 2'd1;
  localparam logic [1:0] REG_INV_SCALE = 2'd2;

  // Lane control from the sequencer
  typedef struct packed {
    logic start;
    logic ack;
  } ild_lane_ctl_t;

  // Lane status back to the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } ild_lane_sts_t;

endpackage

// ===== rtl/imu_linear_downsampler.sv =====
// ----------------------------------------------------------------------------
// imu_linear_downsampler
// An item that makes a result passes through each lane's multiply, bit-serial
// divide, add and scale states and then into the output register.
// The input is taken again the cycle after the lanes hand over to the output
// register, which waits while the output is stalled; an item with no result
// leaves the lanes idle, so the input stays ready. Reset clears the phase, the
// first-sample flag, the previous sample and the output valid, and loads the
// register defaults.
// ----------------------------------------------------------------------------
module imu_linear_downsampler #(
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // fields from bit 0 up: sample_x, sample_y, sample_z
  input  logic [((3*SAMPLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // fields from bit 0 up: scaled_x, scaled_y, scaled_z
  output logic [3*ild_pkg::RES_W-1:0]   m_axis_tdata,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ild_pkg::ADDR_W-1:0]    paddr,
  input  logic [ild_pkg::DATA_W-1:0]    pwdata,
  output logic [ild_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);
  import ild_pkg::*;

  localparam int unsigned SW   = SAMPLE_WIDTH;
  localparam int unsigned IN_W = ((3*SW+7)/8)*8;

  // Configuration registers
  logic [RATE_W-1:0]  rate_mult_q;
  logic [RATE_W-1:0]  rate_div_q;
  logic [SCALE_W-1:0] inv_scale_q;
  logic               cfg_wr;

  // Sequencer state
  logic               started_q;
  logic [PHASE_W-1:0] phase_q, phase_d;
  logic signed [SW-1:0] prev_x_q, prev_y_q, prev_z_q;

  logic signed [SW-1:0] cur_x, cur_y, cur_z;
  logic               in_acc;
  logic               emit;
  logic [PHASE_W-1:0] sub;
  logic [PHASE_W-1:0] base;
  logic [PHASE_W:0]   sum;
  logic [RATE_W-1:0]  m_eff;
  logic signed [RATIO_W-1:0] ratio;

  ild_lane_ctl_t      lane_ctl;
  ild_lane_sts_t      sts_x, sts_y, sts_z;
  logic [RES_W-1:0]   res_x, res_y, res_z;
  logic               ack;

  // APB register file
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_mult_q <= RATE_MULT_RST;
      rate_div_q  <= RATE_DIV_RST;
      inv_scale_q <= INV_SCALE_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_RATE_MULT: rate_mult_q <= pwdata[RATE_W-1:0];
        REG_RATE_DIV:  rate_div_q  <= pwdata[RATE_W-1:0];
        REG_INV_SCALE: inv_scale_q <= pwdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_RATE_MULT: prdata = DATA_W'(rate_mult_q);
      REG_RATE_DIV:  prdata = DATA_W'(rate_div_q);
      REG_INV_SCALE: prdata = DATA_W'(inv_scale_q);
      default:       prdata = '0;
    endcase
  end

  // Input unpacking and handshake
  assign cur_x         = s_axis_tdata[SW-1:0];
  assign cur_y         = s_axis_tdata[2*SW-1:SW];
  assign cur_z         = s_axis_tdata[3*SW-1:2*SW];
  assign s_axis_tready = !sts_x.busy;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Phase bookkeeping; first sample uses ratio equal to the divisor
  assign emit  = !started_q || (phase_q >= {1'b0, rate_div_q});
  assign sub   = phase_q - {1'b0, rate_div_q};
  assign m_eff = (rate_mult_q == '0) ? RATE_W'(1) : rate_mult_q;
  assign ratio = started_q ? ($signed({2'b00, rate_mult_q}) - $signed({1'b0, sub}))
                           : $signed({2'b00, m_eff});
  assign base  = (started_q && emit) ? sub : phase_q;
  assign sum   = {1'b0, base} + {2'b00, rate_mult_q};
  assign phase_d = sum[PHASE_W] ? PHASE_MAX : sum[PHASE_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      phase_q   <= '0;
      prev_x_q  <= '0;
      prev_y_q  <= '0;
      prev_z_q  <= '0;
    end else if (in_acc) begin
      started_q <= 1'b1;
      phase_q   <= phase_d;
      prev_x_q  <= cur_x;
      prev_y_q  <= cur_y;
      prev_z_q  <= cur_z;
    end
  end

  assign lane_ctl.start = in_acc && emit;
  assign lane_ctl.ack   = ack;

  // Three axis lanes in lockstep
  ild_lane #(.SAMPLE_WIDTH(SW)) u_lane_x (
    .clk_i, .rst_ni, .ctl_i(lane_ctl), .sts_o(sts_x),
    .prev_i(prev_x_q), .cur_i(cur_x), .ratio_i(ratio), .div_i(m_eff),
    .scale_i(inv_scale_q), .result_o(res_x)
  );

  ild_lane #(.SAMPLE_WIDTH(SW)) u_lane_y (
    .clk_i, .rst_ni, .ctl_i(lane_ctl), .sts_o(sts_y),
    .prev_i(prev_y_q), .cur_i(cur_y), .ratio_i(ratio), .div_i(m_eff),
    .scale_i(inv_scale_q), .result_o(res_y)
  );

  ild_lane #(.SAMPLE_WIDTH(SW)) u_lane_z (
    .clk_i, .rst_ni, .ctl_i(lane_ctl), .sts_o(sts_z),
    .prev_i(prev_z_q), .cur_i(cur_z), .ratio_i(ratio), .div_i(m_eff),
    .scale_i(inv_scale_q), .result_o(res_z)
  );

  // Merge into the output register
  ild_merge u_merge (
    .clk_i, .rst_ni,
    .lane_done_i(sts_x.done && sts_y.done && sts_z.done),
    .res_x_i(res_x), .res_y_i(res_y), .res_z_i(res_z),
    .ack_o(ack),
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

endmodule

// ===== rtl/ild_lane.sv =====
// ----------------------------------------------------------------------------
// ild_lane
// One axis: multiply the sample step by the phase ratio, divide by the rate
// with a restoring divider (one quotient bit per cycle), add the previous
// sample, saturate, apply the reciprocal scale and saturate again.
// ----------------------------------------------------------------------------
module ild_lane #(
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ild_pkg::ild_lane_ctl_t              ctl_i,
  output ild_pkg::ild_lane_sts_t              sts_o,
  input  logic signed [SAMPLE_WIDTH-1:0]      prev_i,
  input  logic signed [SAMPLE_WIDTH-1:0]      cur_i,
  input  logic signed [ild_pkg::RATIO_W-1:0]  ratio_i,
  input  logic        [ild_pkg::RATE_W-1:0]   div_i,
  input  logic        [ild_pkg::SCALE_W-1:0]  scale_i,
  output logic        [ild_pkg::RES_W-1:0]    result_o
);
  import ild_pkg::*;

  localparam int unsigned DW    = SAMPLE_WIDTH + 1;
  localparam int unsigned PW    = DW + RATIO_W;
  localparam int unsigned VW    = PW + 1;
  localparam int unsigned VX    = (VW > RES_W) ? VW : RES_W;
  localparam int unsigned SPW   = RES_W + SCALE_W + 1;
  localparam int unsigned CNT_W = $clog2(PW);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_ADD,
    ST_SCL,
    ST_FIN
  } state_e;

  state_e state_q, state_d;

  logic signed [DW-1:0]      diff_q;
  logic signed [SAMPLE_WIDTH-1:0] prev_q;
  logic signed [RATIO_W-1:0] ratio_q;
  logic        [RATE_W-1:0]  div_q;
  logic        [SCALE_W-1:0] scale_q;
  logic        [PW-1:0]      dvd_q;
  logic        [RATE_W-1:0]  rem_q;
  logic                      neg_q;
  logic        [CNT_W-1:0]   cnt_q;
  logic signed [RES_W-1:0]   vc_q;
  logic signed [SPW-1:0]     sp_q;

  logic signed [PW-1:0]      prod;
  logic        [PW-1:0]      mag;
  logic        [RATE_W:0]    rem_sh;
  logic                      q_bit;
  logic        [RATE_W:0]    rem_sub;
  logic signed [VW-1:0]      qs;
  logic signed [VW-1:0]      v;
  logic signed [VX-1:0]      v_ext;
  logic                      v_ovf;
  logic        [RES_W-1:0]   v_sat;
  logic signed [SPW-1:0]     sp;
  logic                      sp_ovf;
  logic                      last_step;

  // Step times ratio, then magnitude for the unsigned divider
  assign prod = diff_q * ratio_q;
  assign mag  = prod[PW-1] ? PW'(-prod) : PW'(prod);

  // Restoring divide step
  assign rem_sh    = {rem_q, dvd_q[PW-1]};
  assign q_bit     = (rem_sh >= {1'b0, div_q});
  assign rem_sub   = rem_sh - {1'b0, div_q};
  assign last_step = (cnt_q == CNT_W'(PW - 1));

  // Signed quotient plus previous sample, saturated to 32 bits
  assign qs    = neg_q ? -$signed({1'b0, dvd_q}) : $signed({1'b0, dvd_q});
  assign v     = qs + VW'(prev_q);
  assign v_ext = VX'(v);
  assign v_ovf = !((&v_ext[VX-1:RES_W-1]) || !(|v_ext[VX-1:RES_W-1]));
  assign v_sat = v_ovf ? (v_ext[VX-1] ? RES_MIN : RES_MAX) : v_ext[RES_W-1:0];

  // Reciprocal scale and final saturation
  assign sp       = vc_q * $signed({1'b0, scale_q});
  assign sp_ovf   = !((&sp_q[SPW-1:RES_W-1]) || !(|sp_q[SPW-1:RES_W-1]));
  assign result_o = sp_ovf ? (sp_q[SPW-1] ? RES_MIN : RES_MAX) : sp_q[RES_W-1:0];

  assign sts_o.busy = (state_q != ST_IDLE);
  assign sts_o.done = (state_q == ST_FIN);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (ctl_i.start) state_d = ST_MUL;
      ST_MUL:  state_d = ST_DIV;
      ST_DIV:  if (last_step) state_d = ST_ADD;
      ST_ADD:  state_d = ST_SCL;
      ST_SCL:  state_d = ST_FIN;
      ST_FIN:  if (ctl_i.ack) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (ctl_i.start) begin
          diff_q  <= DW'(cur_i) - DW'(prev_i);
          prev_q  <= prev_i;
          ratio_q <= ratio_i;
          div_q   <= div_i;
          scale_q <= scale_i;
        end
      end
      ST_MUL: begin
        dvd_q <= mag;
        neg_q <= prod[PW-1];
        rem_q <= '0;
        cnt_q <= '0;
      end
      ST_DIV: begin
        dvd_q <= {dvd_q[PW-2:0], q_bit};
        rem_q <= q_bit ? rem_sub[RATE_W-1:0] : rem_sh[RATE_W-1:0];
        cnt_q <= cnt_q + 1'b1;
      end
      ST_ADD: vc_q <= v_sat;
      ST_SCL: sp_q <= sp;
      default: ;
    endcase
  end

endmodule

// ===== rtl/ild_merge.sv =====
// ----------------------------------------------------------------------------
// ild_merge
// Collects the three lane results into one output item and holds it in the
// output register until the downstream side takes it.
// ----------------------------------------------------------------------------
module ild_merge (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        lane_done_i,
  input  logic [ild_pkg::RES_W-1:0]   res_x_i,
  input  logic [ild_pkg::RES_W-1:0]   res_y_i,
  input  logic [ild_pkg::RES_W-1:0]   res_z_i,
  output logic                        ack_o,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // fields from bit 0 up: scaled_x, scaled_y, scaled_z
  output logic [3*ild_pkg::RES_W-1:0] m_axis_tdata
);
  import ild_pkg::*;

  logic                 vld_q, vld_d;
  logic [3*RES_W-1:0]   data_q;

  // Load when all lanes are done and the output slot is free or draining
  assign ack_o = lane_done_i && (!vld_q || m_axis_tready);

  always_comb begin
    vld_d = vld_q;
    if (ack_o) begin
      vld_d = 1'b1;
    end else if (m_axis_tready) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ack_o) begin
      data_q <= {res_z_i, res_y_i, res_x_i};
    end
  end

  assign m_axis_tvalid = vld_q;
  assign m_axis_tdata  = data_q;

endmodule

// ===== rtl/ild_checker.sv =====
// ----------------------------------------------------------------------------
// ild_checker
// Port-level checks for the IMU linear downsampler, bound to the top level.
// ----------------------------------------------------------------------------
module ild_checker #(
  parameter int unsigned IN_W = 48
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [IN_W-1:0]               s_axis_tdata,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [3*ild_pkg::RES_W-1:0]   m_axis_tdata,
  input logic                          psel,
  input logic                          penable,
  input logic                          pwrite,
  input logic [ild_pkg::ADDR_W-1:0]    paddr,
  input logic [ild_pkg::DATA_W-1:0]    pwdata,
  input logic [ild_pkg::DATA_W-1:0]    prdata,
  input logic                          pready
);
  import ild_pkg::*;

  logic seen_q;
  logic in_acc;
  logic wr_mult;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign wr_mult = psel && penable && pwrite && pready && (paddr[3:2] == REG_RATE_MULT);

  // Tracks whether any item has been taken since reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
    end else if (in_acc) begin
      seen_q <= 1'b1;
    end
  end

  // Output item holds while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output data changed while stalled");

  // The first item always makes a result, so the input closes behind it
  a_first_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !seen_q |=> !s_axis_tready)
    else $error("input still ready after first item");

  // A written rate reads back on the next cycle
  a_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_mult ##1 (psel && !pwrite && (paddr[3:2] == REG_RATE_MULT))
    |-> (prdata[RATE_W-1:0] == $past(pwdata[RATE_W-1:0])))
    else $error("rate_mult read-back mismatch");

endmodule

bind imu_linear_downsampler ild_checker #(.IN_W(IN_W)) u_ild_checker (.*);

// ===== tb/sv/imu_linear_downsampler_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_linear_downsampler_checker
// Watches the register port and both streams of the downsampler. It keeps
// its own phase accumulator, previous sample and register copies, works
// out each resampled result when a sample item is taken, and compares every
// result item lane by lane with the oldest one still due.
// ----------------------------------------------------------------------------
module imu_linear_downsampler_checker #(
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned IN_W         = ((3*SAMPLE_WIDTH+7)/8)*8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_tvalid_i,
  input  logic                            in_tready_i,
  // fields from bit 0 up: sample_x, sample_y, sample_z
  input  logic [IN_W-1:0]                 in_tdata_i,
  input  logic                            out_tvalid_i,
  input  logic                            out_tready_i,
  // fields from bit 0 up: scaled_x, scaled_y, scaled_z
  input  logic [3*ild_pkg::RES_W-1:0]     out_tdata_i,
  input  logic                            psel_i,
  input  logic                            penable_i,
  input  logic                            pwrite_i,
  input  logic                            pready_i,
  input  logic [ild_pkg::ADDR_W-1:0]      paddr_i,
  input  logic [ild_pkg::DATA_W-1:0]      pwdata_i,
  output int unsigned                     fail_count_o,
  output int unsigned                     pending_o
);

  localparam int unsigned RES_W = ild_pkg::RES_W;
  localparam longint RES_HI = longint'($signed(ild_pkg::RES_MAX));
  localparam longint RES_LO = longint'($signed(ild_pkg::RES_MIN));

  // register copies
  logic [ild_pkg::RATE_W-1:0]  rate_mult;
  logic [ild_pkg::RATE_W-1:0]  rate_div;
  logic [ild_pkg::SCALE_W-1:0] inv_scale;

  // resampler state
  logic [ild_pkg::PHASE_W-1:0]    phase;
  bit                             started;
  logic signed [SAMPLE_WIDTH-1:0] prev_smp [3];

  logic [3*RES_W-1:0] due_results [$];
  int unsigned        fails;

  function automatic string lane_name(int lane);
    case (lane)
      0:       return "scaled_x";
      1:       return "scaled_y";
      default: return "scaled_z";
    endcase
  endfunction

  function automatic longint sat_res(longint v);
    if (v > RES_HI) return RES_HI;
    if (v < RES_LO) return RES_LO;
    return v;
  endfunction

  // interpolated value times the reciprocal scale, Q16.16, saturated twice
  function automatic logic [RES_W-1:0] scale_lane(longint v);
    longint prod;
    prod = sat_res(sat_res(v) * longint'(inv_scale));
    return prod[RES_W-1:0];
  endfunction

  // advance the resampler by one sample; returns 1 when a result is due
  function automatic bit resample(input logic [IN_W-1:0] data,
                                  output logic [3*RES_W-1:0] res);
    logic signed [SAMPLE_WIDTH-1:0] cur [3];
    logic [ild_pkg::PHASE_W:0]      acc;
    longint sub, ratio, divisor, p, c;
    bit made;
    made = 1'b0;
    res  = '0;
    for (int i = 0; i < 3; i++) cur[i] = data[i*SAMPLE_WIDTH +: SAMPLE_WIDTH];
    if (!started) begin
      // first sample goes straight through, phase not reduced
      for (int i = 0; i < 3; i++) res[i*RES_W +: RES_W] = scale_lane(longint'(cur[i]));
      started = 1'b1;
      made    = 1'b1;
    end else if (phase >= rate_div) begin
      sub     = longint'(phase) - longint'(rate_div);
      ratio   = longint'(rate_mult) - sub;
      divisor = (rate_mult != '0) ? longint'(rate_mult) : 64'sd1;
      for (int i = 0; i < 3; i++) begin
        p = prev_smp[i];
        c = cur[i];
        // SV division on longint truncates toward zero
        res[i*RES_W +: RES_W] = scale_lane(p + (ratio * (c - p)) / divisor);
      end
      phase = phase - ild_pkg::PHASE_W'(rate_div);
      made  = 1'b1;
    end
    acc   = phase + rate_mult;
    phase = (acc > ild_pkg::PHASE_MAX) ? ild_pkg::PHASE_MAX : acc[ild_pkg::PHASE_W-1:0];
    for (int i = 0; i < 3; i++) prev_smp[i] = cur[i];
    return made;
  endfunction

  task automatic note_fail(string msg);
    fails++;
    if (fails <= 10) $display("%s", msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    logic [3*RES_W-1:0] want;
    if (!rst_ni) begin
      rate_mult = ild_pkg::RATE_MULT_RST;
      rate_div  = ild_pkg::RATE_DIV_RST;
      inv_scale = ild_pkg::INV_SCALE_RST;
      phase     = '0;
      started   = 1'b0;
      for (int i = 0; i < 3; i++) prev_smp[i] = '0;
      due_results.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // register writes
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[3:2])
          ild_pkg::REG_RATE_MULT: rate_mult = pwdata_i[ild_pkg::RATE_W-1:0];
          ild_pkg::REG_RATE_DIV:  rate_div  = pwdata_i[ild_pkg::RATE_W-1:0];
          ild_pkg::REG_INV_SCALE: inv_scale = pwdata_i[ild_pkg::SCALE_W-1:0];
          default: ;
        endcase
      end
      // sample item taken
      if (in_tvalid_i && in_tready_i) begin
        if (resample(in_tdata_i, want)) due_results.push_back(want);
      end
      // result item taken
      if (out_tvalid_i && out_tready_i) begin
        if (due_results.size() == 0) begin
          note_fail($sformatf("unexpected result item %h", out_tdata_i));
        end else begin
          want = due_results.pop_front();
          for (int i = 0; i < 3; i++) begin
            if (out_tdata_i[i*RES_W +: RES_W] !== want[i*RES_W +: RES_W])
              note_fail($sformatf("%s: expected %0d, got %0d", lane_name(i),
                                  $signed(want[i*RES_W +: RES_W]),
                                  $signed(out_tdata_i[i*RES_W +: RES_W])));
          end
        end
      end
      pending_o    <= due_results.size();
      fail_count_o <= fails;
    end
  end

endmodule

// ===== tb/sv/imu_linear_downsampler_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_linear_downsampler_tb
// Drives IMU sample items through the downsampler under a series of rate
// and scale settings, with random gaps and stalls on both streams. A
// separate checker predicts and compares the results; this module makes
// the stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module imu_linear_downsampler_tb;

  localparam int unsigned SAMPLE_W      = 16;
  localparam int unsigned IN_W          = ((3*SAMPLE_W+7)/8)*8;
  localparam int unsigned RES_W         = ild_pkg::RES_W;
  localparam int unsigned SETTLE_CYCLES = SAMPLE_W + 30;
  localparam int unsigned RANDOM_ITEMS  = 950;

  // sample extremes and bit patterns
  localparam logic [SAMPLE_W-1:0] S_MAX  = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic [SAMPLE_W-1:0] S_MIN  = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic [SAMPLE_W-1:0] S_ZERO = '0;
  localparam logic [SAMPLE_W-1:0] S_ONES = '1;
  localparam logic [SAMPLE_W-1:0] S_ALT  = {(SAMPLE_W/2){2'b01}};
  localparam logic [SAMPLE_W-1:0] S_ALTN = {(SAMPLE_W/2){2'b10}};

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [IN_W-1:0]              s_axis_tdata = '0;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [3*RES_W-1:0]           m_axis_tdata;
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [ild_pkg::ADDR_W-1:0]   paddr = '0;
  logic [ild_pkg::DATA_W-1:0]   pwdata = '0;
  logic [ild_pkg::DATA_W-1:0]   prdata;
  logic                         pready;

  int unsigned fail_count;
  int unsigned results_due;
  bit          calm = 1'b0;

  always #10 clk = ~clk;

  imu_linear_downsampler #(
    .SAMPLE_WIDTH(SAMPLE_W)
  ) i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  imu_linear_downsampler_checker #(
    .SAMPLE_WIDTH(SAMPLE_W)
  ) i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_tvalid_i  (s_axis_tvalid),
    .in_tready_i  (s_axis_tready),
    .in_tdata_i   (s_axis_tdata),
    .out_tvalid_i (m_axis_tvalid),
    .out_tready_i (m_axis_tready),
    .out_tdata_i  (m_axis_tdata),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .fail_count_o (fail_count),
    .pending_o    (results_due)
  );

  // mostly short gaps, now and then a long one
  function automatic int unsigned idle_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 120);
  endfunction

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 11))
      0:       return S_MAX;
      1:       return S_MIN;
      2:       return S_ZERO;
      3:       return S_ONES;
      default: return SAMPLE_W'($urandom());
    endcase
  endfunction

  task automatic send_sample(logic [SAMPLE_W-1:0] x, logic [SAMPLE_W-1:0] y,
                             logic [SAMPLE_W-1:0] z);
    int unsigned gap;
    gap = idle_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_W'({z, y, x});
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // hold the sender until every due result is out and the lanes settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [ild_pkg::DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ild_pkg::ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_rates(logic [15:0] mult, logic [15:0] div, logic [16:0] scale);
    drain();
    write_reg(ild_pkg::REG_RATE_MULT, ild_pkg::DATA_W'(mult));
    write_reg(ild_pkg::REG_RATE_DIV, ild_pkg::DATA_W'(div));
    write_reg(ild_pkg::REG_INV_SCALE, ild_pkg::DATA_W'(scale));
  endtask

  // result side: ready with random stalls, steady while calm
  initial begin : result_sink
    int unsigned hold, gap;
    wait (rst_n);
    @(posedge clk);
    forever begin
      m_axis_tready <= 1'b1;
      hold = calm ? 200 : $urandom_range(1, 30);
      repeat (hold) @(posedge clk);
      gap = idle_gap();
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    logic [SAMPLE_W-1:0] walk [3];
    logic [15:0]         mult, div;
    logic [16:0]         scale;
    int unsigned         sent, span, style;
    bit                  paused;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: first sample passes through, then each sample as is
    send_sample(S_MAX, S_MIN, S_ZERO);
    send_sample(S_MIN, S_MAX, S_ONES);
    send_sample(S_ZERO, S_ONES, S_MAX);
    send_sample(S_ALT, S_ALTN, S_ALT);
    send_sample(S_ALTN, S_ALT, S_ALTN);

    // fractional rate, half scale
    set_rates(16'd3, 16'd7, 17'd32768);
    send_sample(S_MAX, S_ZERO, S_MIN);
    send_sample(S_MIN, S_MAX, S_ZERO);
    send_sample(S_MAX, S_MIN, S_ONES);
    send_sample(S_ZERO, S_MAX, S_MIN);
    send_sample(S_ONES, S_ALT, S_ALTN);

    // zero rate_mult with zero rate_div: a result per item, divisor one
    set_rates(16'd0, 16'd0, 17'd65536);
    send_sample(S_MAX, S_MIN, S_ZERO);
    send_sample(S_MIN, S_MAX, S_ONES);
    send_sample(S_ALT, S_ALTN, S_MAX);

    // zero rate_mult, phase never grows
    set_rates(16'd0, 16'd4, 17'd1);
    send_sample(S_MIN, S_MAX, S_ALT);
    send_sample(S_MAX, S_MIN, S_ALTN);

    // overflowing phase: extrapolation runs past the sample range
    set_rates(16'hffff, 16'd1, 17'd65536);
    send_sample(S_MIN, S_MAX, S_ZERO);
    send_sample(S_MAX, S_MIN, S_ONES);
    send_sample(S_MIN, S_MAX, S_MAX);
    send_sample(S_MAX, S_MIN, S_MIN);
    send_sample(S_ZERO, S_ZERO, S_ZERO);

    // slowest rate, scale zero
    set_rates(16'd1, 16'hffff, 17'd0);
    send_sample(S_MAX, S_MIN, S_ONES);
    send_sample(S_MIN, S_MAX, S_ZERO);

    // random phases
    sent   = 0;
    paused = 1'b0;
    for (int i = 0; i < 3; i++) walk[i] = SAMPLE_W'($urandom());
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 5))
        0: begin
          mult = 16'($urandom_range(1, 16));
          div  = 16'($urandom_range(mult, 24));
          span = 60;
        end
        1: begin
          div  = 16'($urandom_range(1, 65535));
          mult = div - 16'($urandom_range(0, div / 2));
          span = 60;
        end
        2: begin
          div  = 16'($urandom_range(0, 2000));
          mult = 16'($urandom_range(div + 1, 65535));
          span = 80;
        end
        3: begin
          div  = 16'd0;
          mult = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(0, 65535));
          span = 40;
        end
        4: begin
          mult = 16'd0;
          div  = 16'($urandom_range(1, 5));
          span = 15;
        end
        default: begin
          mult = $urandom_range(0, 1) ? 16'hffff : 16'd1;
          div  = $urandom_range(0, 1) ? 16'hffff : 16'd1;
          span = 30;
        end
      endcase
      case ($urandom_range(0, 4))
        0:       scale = 17'd0;
        1:       scale = 17'd65536;
        2:       scale = 17'd1;
        default: scale = 17'($urandom_range(0, 65536));
      endcase
      set_rates(mult, div, scale);
      calm  = ($urandom_range(0, 3) == 0);
      style = $urandom_range(0, 1);
      if (span > RANDOM_ITEMS - sent) span = RANDOM_ITEMS - sent;
      repeat (span) begin
        if (style == 0) begin
          send_sample(rand_sample(), rand_sample(), rand_sample());
        end else begin
          // smooth motion, the usual shape of sensor data
          for (int i = 0; i < 3; i++)
            walk[i] = walk[i] + SAMPLE_W'($urandom_range(0, 1023)) - SAMPLE_W'(512);
          send_sample(walk[0], walk[1], walk[2]);
        end
        sent++;
        // sender holds off until all due results are out
        if (!paused && sent >= RANDOM_ITEMS / 2 || $urandom_range(0, 99) == 0) begin
          paused = 1'b1;
          drain();
        end
      end
    end
    calm = 1'b0;

    drain();
    if (fail_count == 0 && results_due == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin : watchdog
    #30ms;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ild_pkg.sv
rtl/ild_lane.sv
rtl/ild_merge.sv
rtl/imu_linear_downsampler.sv
rtl/ild_checker.sv
tb/sv/imu_linear_downsampler_checker.sv
tb/sv/imu_linear_downsampler_tb.sv
